/* rtl/hba_pkg.sv */
// Shared types and constants of the heap block allocator.
// Used by the block table, the adder unit, the top level, the checker and the testbench.
`default_nettype none

package hba_pkg;

   // Heap geometry
   localparam logic [16:0] HEAP_BYTES   = 17'd65536;
   localparam logic [16:0] HEADER_BYTES = 17'd20;
   localparam logic [16:0] LIMIT_RESET  = 17'd65536;

   // Request codes
   localparam logic [2:0] RQ_ALLOC     = 3'd0;
   localparam logic [2:0] RQ_FREE      = 3'd1;
   localparam logic [2:0] RQ_FIND_ADDR = 3'd2;
   localparam logic [2:0] RQ_FIND_SIZE = 3'd3;
   localparam logic [2:0] RQ_SPLIT     = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
   localparam logic [2:0] ST_NO_SPACE   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_TOO_SMALL  = 3'd4;
   localparam logic [2:0] ST_TABLE_FULL = 3'd5;

   // One block table entry
   typedef struct packed {
      logic [15:0] start;
      logic [16:0] req_size;
      logic [16:0] aligned_size;
      logic        is_free;
   } entry_type;

   typedef enum logic [0:0] {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ALLOC,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_PRED_RD,
      S_PRED_CHK,
      S_MRG_AL,
      S_MRG_REQ,
      S_SUCC_DEC,
      S_SUCC_CHK,
      S_COMPACT,
      S_MOVE_RD,
      S_MOVE_WR,
      S_SPLIT_REQ,
      S_SPLIT_ST,
      S_SPLIT_WR1,
      S_DONE
   } state_type;

   // Round up to a multiple of four and add the header
   function automatic logic [16:0] padded_bytes(input logic [15:0] n);
      logic [16:0] rounded;
      rounded = ({1'b0, n} + 17'd3) & ~17'd3;
      return rounded + HEADER_BYTES;
   endfunction

endpackage

`default_nettype wire

/* rtl/hba_channels.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing but plain logic types.
`default_nettype none

interface hba_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [15:0] address;
   logic [15:0] size;

   modport source (output valid, req_type, address, size, input ready);
   modport sink   (input valid, req_type, address, size, output ready);
endinterface

interface hba_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] block_address;
   logic [16:0] block_req_size;
   logic [16:0] block_aligned_size;
   logic        block_is_free;
   logic [16:0] heap_top_out;

   modport source (output valid, status, block_address, block_req_size,
                   block_aligned_size, block_is_free, heap_top_out, input ready);
   modport sink   (input valid, status, block_address, block_req_size,
                   block_aligned_size, block_is_free, heap_top_out, output ready);
endinterface

`default_nettype wire

/* rtl/hba_table.sv */
// Block table memory: one write port, one read port with registered data.
// Depends on hba_pkg for the entry type.
`default_nettype none

module hba_table
   import hba_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic [IW-1:0] rd_addr,
   output entry_type          rd_data
);

   entry_type mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/hba_alu.sv */
// Shared 17-bit add/subtract unit with borrow out, driven by the sequencer.
// Depends on hba_pkg for the operation type.
`default_nettype none

module hba_alu
   import hba_pkg::*;
(
   input  wire alu_op_type  op,
   input  wire logic [16:0] a,
   input  wire logic [16:0] b,
   output logic [17:0]      res
);

   // Bit 17 is carry for add and borrow for subtract
   always_comb begin
      case (op)
         ALU_ADD: res = {1'b0, a} + {1'b0, b};
         ALU_SUB: res = {1'b0, a} - {1'b0, b};
         default: res = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/heap_block_allocator.sv */
// Alloc: the request passes through the alloc and done states; the done state waits until the
// output register is free and loads the response. Other requests scan the table with a read
// and a check state per entry (table read port), then free and split move each shifted entry
// with a read and a write state, plus the merge steps. One request at a time; a new request is taken while
// the previous response still waits on the output register.
// Reset clears the entry count, heap top and response valid and sets the limit to 65536;
// table contents are not cleared, entries beyond the count are never read.
`default_nettype none

module heap_block_allocator
   import hba_pkg::*;
#(
   parameter int MAX_BLOCKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hba_req_if.sink          req_chan,
   hba_rsp_if.source        rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int XW = CW + 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BLOCKS);

   state_type state_ff, state_in;

   logic [2:0]    rq_type_ff, rq_type_in;
   logic [15:0]   rq_addr_ff, rq_addr_in;
   logic [15:0]   rq_size_ff, rq_size_in;
   logic [16:0]   bsize_ff, bsize_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] hit_ff, hit_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [1:0]    ndrop_ff, ndrop_in;
   logic          succ_ff, succ_in;
   logic          mv_up_ff, mv_up_in;
   entry_type     cur_ff, cur_in;
   entry_type     oth_ff, oth_in;
   logic [CW-1:0] count_ff, count_in;
   logic [16:0]   top_ff, top_in;
   logic [16:0]   limit_ff, limit_in;
   logic [2:0]    res_status_ff, res_status_in;
   entry_type     res_entry_ff, res_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [16:0]   rsp_top_ff, rsp_top_in;

   logic          tb_we;
   logic [IW-1:0] tb_waddr;
   entry_type     tb_wdata;
   logic [IW-1:0] tb_raddr;
   entry_type     tb_rdata;

   alu_op_type    alu_op;
   logic [16:0]   alu_a;
   logic [16:0]   alu_b;
   logic [17:0]   alu_res;

   logic          req_fire;
   logic          rsp_free;
   logic [16:0]   limit_eff;
   logic          match_w;
   logic          more_scan;
   logic          hit_last;
   logic          table_full;
   logic          no_space;
   logic          too_small;
   logic [XW-1:0] compact_src;
   logic          compact_more;
   logic          more_up;
   logic          more_dn;

   hba_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
      .clock   (clock),
      .wr_en   (tb_we),
      .wr_addr (tb_waddr),
      .wr_data (tb_wdata),
      .rd_addr (tb_raddr),
      .rd_data (tb_rdata)
   );

   hba_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   // Handshake and conditions
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign limit_eff      = (limit_ff < HEAP_BYTES) ? limit_ff : HEAP_BYTES;

   assign match_w    = (rq_type_ff == RQ_FIND_SIZE) ?
                       (tb_rdata.req_size == {1'b0, rq_size_ff}) :
                       (tb_rdata.start == rq_addr_ff);
   assign more_scan  = (XW'(idx_ff) + XW'(1)) < XW'(count_ff);
   assign hit_last   = !((XW'(hit_ff) + XW'(1)) < XW'(count_ff));
   assign table_full = (count_ff >= MAX_COUNT);
   assign no_space   = alu_res > {1'b0, limit_eff};
   assign too_small  = alu_res[17] || (alu_res[16:0] == 17'd0);
   assign compact_src  = XW'(pos_ff) + XW'(1) + XW'(ndrop_ff);
   assign compact_more = compact_src < XW'(count_ff);
   assign more_up    = XW'(idx_ff) > (XW'(hit_ff) + XW'(1));
   assign more_dn    = (XW'(idx_ff) + XW'(1)) < XW'(count_ff);

   // Response port
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = rsp_status_ff;
   assign rsp_chan.block_address      = rsp_entry_ff.start;
   assign rsp_chan.block_req_size     = rsp_entry_ff.req_size;
   assign rsp_chan.block_aligned_size = rsp_entry_ff.aligned_size;
   assign rsp_chan.block_is_free      = rsp_entry_ff.is_free;
   assign rsp_chan.heap_top_out       = rsp_top_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.req_type)
                  RQ_ALLOC: state_in = S_ALLOC;
                  RQ_FREE, RQ_FIND_ADDR, RQ_FIND_SIZE, RQ_SPLIT: begin
                     state_in = (count_ff == '0) ? S_DONE : S_SCAN_RD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ALLOC:   state_in = S_DONE;
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (match_w) begin
               case (rq_type_ff)
                  RQ_FREE: state_in = (idx_ff != '0) ? S_PRED_RD : S_SUCC_DEC;
                  RQ_SPLIT: begin
                     if (too_small || table_full) begin
                        state_in = S_DONE;
                     end else if (more_scan) begin
                        state_in = S_MOVE_RD;
                     end else begin
                        state_in = S_SPLIT_REQ;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end else begin
               state_in = more_scan ? S_SCAN_RD : S_DONE;
            end
         end
         S_PRED_RD:  state_in = S_PRED_CHK;
         S_PRED_CHK: state_in = tb_rdata.is_free ? S_MRG_AL : S_SUCC_DEC;
         S_MRG_AL:   state_in = S_MRG_REQ;
         S_MRG_REQ:  state_in = succ_ff ? S_COMPACT : S_SUCC_DEC;
         S_SUCC_DEC: state_in = hit_last ? S_DONE : S_SUCC_CHK;
         S_SUCC_CHK: state_in = tb_rdata.is_free ? S_MRG_AL : S_COMPACT;
         S_COMPACT: begin
            state_in = (ndrop_ff != 2'd0 && compact_more) ? S_MOVE_RD : S_DONE;
         end
         S_MOVE_RD: state_in = S_MOVE_WR;
         S_MOVE_WR: begin
            if (mv_up_ff) begin
               state_in = more_up ? S_MOVE_RD : S_SPLIT_REQ;
            end else begin
               state_in = more_dn ? S_MOVE_RD : S_DONE;
            end
         end
         S_SPLIT_REQ: state_in = S_SPLIT_ST;
         S_SPLIT_ST:  state_in = S_SPLIT_WR1;
         S_SPLIT_WR1: state_in = S_DONE;
         S_DONE:      state_in = rsp_free ? S_IDLE : S_DONE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath, table and adder control
   always_comb begin
      rq_type_in    = rq_type_ff;
      rq_addr_in    = rq_addr_ff;
      rq_size_in    = rq_size_ff;
      bsize_in      = bsize_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      pos_in        = pos_ff;
      ndrop_in      = ndrop_ff;
      succ_in       = succ_ff;
      mv_up_in      = mv_up_ff;
      cur_in        = cur_ff;
      oth_in        = oth_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_top_in    = rsp_top_ff;
      tb_we         = 1'b0;
      tb_waddr      = pos_ff;
      tb_wdata      = cur_ff;
      tb_raddr      = idx_ff;
      alu_op        = ALU_ADD;
      alu_a         = cur_ff.aligned_size;
      alu_b         = oth_ff.aligned_size;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rq_type_in    = req_chan.req_type;
               rq_addr_in    = req_chan.address;
               rq_size_in    = req_chan.size;
               bsize_in      = padded_bytes(req_chan.size);
               idx_in        = '0;
               ndrop_in      = 2'd0;
               succ_in       = 1'b0;
               res_status_in = ST_NOT_FOUND;
               res_entry_in  = '0;
            end
         end
         S_ALLOC: begin
            alu_a = top_ff;
            alu_b = bsize_ff;
            if (rq_size_ff == 16'd0) begin
               res_status_in = ST_BAD_SIZE;
            end else if (table_full) begin
               res_status_in = ST_TABLE_FULL;
            end else if (no_space) begin
               res_status_in = ST_NO_SPACE;
            end else begin
               tb_we         = 1'b1;
               tb_waddr      = count_ff[IW-1:0];
               tb_wdata      = '{start: top_ff[15:0], req_size: {1'b0, rq_size_ff},
                                 aligned_size: bsize_ff, is_free: 1'b0};
               count_in      = count_ff + CW'(1);
               top_in        = alu_res[16:0];
               res_status_in = ST_OK;
               res_entry_in  = tb_wdata;
            end
         end
         S_SCAN_RD: tb_raddr = idx_ff;
         S_SCAN_CHK: begin
            alu_op = ALU_SUB;
            alu_a  = tb_rdata.aligned_size;
            alu_b  = bsize_ff;
            if (match_w) begin
               hit_in = idx_ff;
               pos_in = idx_ff;
               cur_in = tb_rdata;
               case (rq_type_ff)
                  RQ_FREE: cur_in.is_free = 1'b1;
                  RQ_SPLIT: begin
                     if (too_small) begin
                        res_status_in = ST_TOO_SMALL;
                     end else if (table_full) begin
                        res_status_in = ST_TABLE_FULL;
                     end else begin
                        cur_in.aligned_size = alu_res[16:0];
                        idx_in              = IW'(count_ff - CW'(1));
                        mv_up_in            = 1'b1;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                     res_entry_in  = tb_rdata;
                  end
               endcase
            end else if (more_scan) begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_PRED_RD: tb_raddr = hit_ff - IW'(1);
         S_PRED_CHK: begin
            if (tb_rdata.is_free) begin
               oth_in   = cur_ff;
               cur_in   = tb_rdata;
               pos_in   = hit_ff - IW'(1);
               ndrop_in = 2'd1;
            end
         end
         S_MRG_AL: begin
            cur_in.aligned_size = alu_res[16:0];
         end
         S_MRG_REQ: begin
            alu_a          = cur_ff.req_size;
            alu_b          = oth_ff.req_size;
            cur_in.req_size = alu_res[16:0];
            cur_in.is_free  = 1'b1;
         end
         S_SUCC_DEC: begin
            tb_raddr = hit_ff + IW'(1);
            if (hit_last) begin
               count_in      = CW'(pos_ff);
               top_in        = {1'b0, cur_ff.start};
               res_status_in = ST_OK;
               res_entry_in  = cur_ff;
            end
         end
         S_SUCC_CHK: begin
            if (tb_rdata.is_free) begin
               oth_in   = tb_rdata;
               ndrop_in = ndrop_ff + 2'd1;
               succ_in  = 1'b1;
            end
         end
         S_COMPACT: begin
            tb_we         = 1'b1;
            tb_waddr      = pos_ff;
            tb_wdata      = cur_ff;
            res_status_in = ST_OK;
            res_entry_in  = cur_ff;
            mv_up_in      = 1'b0;
            if (ndrop_ff != 2'd0) begin
               if (compact_more) begin
                  idx_in = compact_src[IW-1:0];
               end else begin
                  count_in = count_ff - CW'(ndrop_ff);
               end
            end
         end
         S_MOVE_RD: tb_raddr = idx_ff;
         S_MOVE_WR: begin
            tb_we    = 1'b1;
            tb_wdata = tb_rdata;
            if (mv_up_ff) begin
               tb_waddr = idx_ff + IW'(1);
               if (more_up) begin
                  idx_in = idx_ff - IW'(1);
               end
            end else begin
               tb_waddr = idx_ff - IW'(ndrop_ff);
               if (more_dn) begin
                  idx_in = idx_ff + IW'(1);
               end else begin
                  count_in = count_ff - CW'(ndrop_ff);
               end
            end
         end
         S_SPLIT_REQ: begin
            alu_op          = ALU_SUB;
            alu_a           = cur_ff.req_size;
            alu_b           = {1'b0, rq_size_ff};
            cur_in.req_size = alu_res[17] ? 17'd0 : alu_res[16:0];
         end
         S_SPLIT_ST: begin
            alu_a    = {1'b0, cur_ff.start};
            alu_b    = cur_ff.aligned_size;
            tb_we    = 1'b1;
            tb_waddr = hit_ff;
            tb_wdata = cur_ff;
            oth_in   = '{start: alu_res[15:0], req_size: {1'b0, rq_size_ff},
                         aligned_size: bsize_ff, is_free: 1'b1};
         end
         S_SPLIT_WR1: begin
            tb_we         = 1'b1;
            tb_waddr      = hit_ff + IW'(1);
            tb_wdata      = oth_ff;
            count_in      = count_ff + CW'(1);
            res_status_in = ST_OK;
            res_entry_in  = oth_ff;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_top_in    = top_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rq_type_ff    <= rq_type_in;
      rq_addr_ff    <= rq_addr_in;
      rq_size_ff    <= rq_size_in;
      bsize_ff      <= bsize_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      pos_ff        <= pos_in;
      ndrop_ff      <= ndrop_in;
      succ_ff       <= succ_in;
      mv_up_ff      <= mv_up_in;
      cur_ff        <= cur_in;
      oth_ff        <= oth_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_top_ff    <= rsp_top_in;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("entry count beyond table depth");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (top_ff == 17'd0))
      else $error("empty table with non-zero heap top");

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= HEAP_BYTES)
      else $error("heap top beyond heap size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done step");
`endif

endmodule

`default_nettype wire

/* test/hba_checker.sv */
// Checker for the heap block allocator: watches the request, response and register ports.
// Predicts each response and compares it with what the block returns.
// Depends on hba_pkg and the channel interfaces in hba_channels.sv.
`default_nettype none

module hba_checker
   import hba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   hba_req_if               req_mon,
   hba_rsp_if               rsp_mon,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data,
   output int               error_count,
   output int               outstanding
);

   localparam int TABLE_DEPTH = 16;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] block_address;
      logic [16:0] block_req_size;
      logic [16:0] block_aligned_size;
      logic        block_is_free;
      logic [16:0] heap_top_out;
   } alloc_rsp_type;

   // Shadow copy of the block table and heap state
   int unsigned blk_start[TABLE_DEPTH];
   int unsigned blk_req[TABLE_DEPTH];
   int unsigned blk_aligned[TABLE_DEPTH];
   bit          blk_free[TABLE_DEPTH];
   int unsigned blk_count;
   int unsigned top_offset;
   int unsigned limit_reg;

   alloc_rsp_type pending_rsp[$];

   function automatic int find_start(int unsigned addr);
      for (int m = 0; m < blk_count; m++)
         if (blk_start[m] == addr) return m;
      return -1;
   endfunction

   function automatic int unsigned padded_size(int unsigned n);
      return ((n + 3) & ~32'd3) + HEADER_BYTES;
   endfunction

   function automatic void drop_block(int unsigned j);
      for (int unsigned m = j; m + 1 < blk_count; m++) begin
         blk_start[m]   = blk_start[m + 1];
         blk_req[m]     = blk_req[m + 1];
         blk_aligned[m] = blk_aligned[m + 1];
         blk_free[m]    = blk_free[m + 1];
      end
      blk_count--;
   endfunction

   function automatic void merge_successor(int unsigned j);
      if (j + 1 < blk_count && blk_free[j + 1]) begin
         blk_aligned[j] += blk_aligned[j + 1];
         blk_req[j]     += blk_req[j + 1];
         drop_block(j + 1);
      end
   endfunction

   // Work out the response to one request and update the shadow state
   function automatic alloc_rsp_type predict_response(logic [2:0] kind, logic [15:0] addr,
                                                      logic [15:0] size);
      alloc_rsp_type r;
      int unsigned   lim, blk, i;
      int            k;
      lim = (limit_reg < HEAP_BYTES) ? limit_reg : HEAP_BYTES;
      r = '{ST_NOT_FOUND, '0, '0, '0, 1'b0, '0};
      case (kind)
         RQ_ALLOC: begin
            blk = padded_size(size);
            if (size == 0) r.status = ST_BAD_SIZE;
            else if (blk_count >= TABLE_DEPTH) r.status = ST_TABLE_FULL;
            else if (top_offset + blk > lim) r.status = ST_NO_SPACE;
            else begin
               blk_start[blk_count]   = top_offset;
               blk_req[blk_count]     = size;
               blk_aligned[blk_count] = blk;
               blk_free[blk_count]    = 1'b0;
               blk_count++;
               r = '{ST_OK, top_offset[15:0], {1'b0, size}, blk[16:0], 1'b0, '0};
               top_offset += blk;
            end
         end
         RQ_FREE: begin
            k = find_start(addr);
            if (k >= 0) begin
               i = k;
               blk_free[i] = 1'b1;
               if (i > 0 && blk_free[i - 1]) begin
                  merge_successor(i - 1);
                  i--;
               end
               r.block_address = blk_start[i][15:0];
               if (i + 1 < blk_count) merge_successor(i);
               else begin
                  top_offset = blk_start[i];
                  blk_count  = i;
               end
               r.block_req_size     = blk_req[i][16:0];
               r.block_aligned_size = blk_aligned[i][16:0];
               r.block_is_free      = 1'b1;
               r.status             = ST_OK;
            end
         end
         RQ_FIND_ADDR, RQ_FIND_SIZE: begin
            k = -1;
            if (kind == RQ_FIND_ADDR) k = find_start(addr);
            else begin
               for (int m = 0; m < blk_count; m++)
                  if (blk_req[m] == size) begin
                     k = m;
                     break;
                  end
            end
            if (k >= 0)
               r = '{ST_OK, blk_start[k][15:0], blk_req[k][16:0], blk_aligned[k][16:0],
                     blk_free[k], '0};
         end
         RQ_SPLIT: begin
            blk = padded_size(size);
            k = find_start(addr);
            if (k < 0) r.status = ST_NOT_FOUND;
            else if (blk_aligned[k] <= blk) r.status = ST_TOO_SMALL;
            else if (blk_count >= TABLE_DEPTH) r.status = ST_TABLE_FULL;
            else begin
               i = k;
               // open a slot after the split block
               for (int unsigned m = blk_count - 1; m > i; m--) begin
                  blk_start[m + 1]   = blk_start[m];
                  blk_req[m + 1]     = blk_req[m];
                  blk_aligned[m + 1] = blk_aligned[m];
                  blk_free[m + 1]    = blk_free[m];
               end
               blk_count++;
               blk_aligned[i] -= blk;
               blk_req[i] = (blk_req[i] > size) ? blk_req[i] - size : 0;
               blk_start[i + 1]   = blk_start[i] + blk_aligned[i];
               blk_req[i + 1]     = size;
               blk_aligned[i + 1] = blk;
               blk_free[i + 1]    = 1'b1;
               r = '{ST_OK, blk_start[i + 1][15:0], {1'b0, size}, blk[16:0], 1'b1, '0};
            end
         end
         default: ;
      endcase
      r.heap_top_out = top_offset[16:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         blk_count   = 0;
         top_offset  = 0;
         limit_reg   = LIMIT_RESET;
         error_count = 0;
         pending_rsp.delete();
      end else begin
         if (csr_wr_en) limit_reg = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            pending_rsp.push_back(predict_response(req_mon.req_type, req_mon.address,
                                                   req_mon.size));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response transfer with no request waiting");
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("status", 17'(want.status), 17'(rsp_mon.status));
               check_field("block_address", 17'(want.block_address),
                           17'(rsp_mon.block_address));
               check_field("block_req_size", want.block_req_size, rsp_mon.block_req_size);
               check_field("block_aligned_size", want.block_aligned_size,
                           rsp_mon.block_aligned_size);
               check_field("block_is_free", 17'(want.block_is_free),
                           17'(rsp_mon.block_is_free));
               check_field("heap_top_out", want.heap_top_out, rsp_mon.heap_top_out);
            end
         end
      end
      outstanding = pending_rsp.size();
   end

endmodule

`default_nettype wire

/* test/tb.sv */
// Top of the heap block allocator testbench: clock, reset, stimulus and verdict.
// Depends on hba_pkg, hba_channels.sv, heap_block_allocator and hba_checker.
`default_nettype none

module tb;
   import hba_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;
   int          error_count;
   int          outstanding;
   int          send_gap_pct = 0;
   int          recv_gap_pct = 0;
   int          quiet_cycles = 0;
   logic [15:0] known_starts[$];

   hba_req_if req_chan();
   hba_rsp_if rsp_chan();

   heap_block_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hba_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.req_type = RQ_ALLOC;
      req_chan.address  = '0;
      req_chan.size     = '0;
      rsp_chan.ready    = 1'b0;
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_gap_pct);
   end

   // Remember block starts that the block has reported, for address reuse
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready && rsp_chan.status == ST_OK) begin
         known_starts.push_back(rsp_chan.block_address);
         if (known_starts.size() > 24) void'(known_starts.pop_front());
      end
   end

   // Abort when nothing transfers for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send(logic [2:0] kind, logic [15:0] addr, logic [15:0] size);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.address  <= addr;
      req_chan.size     <= size;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold until every response is back, then write the limit
   task automatic set_limit(logic [16:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [15:0] pick_address();
      if (known_starts.size() > 0 && $urandom_range(99) < 80)
         return known_starts[$urandom_range(known_starts.size() - 1)];
      return $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(400) * 4);
   endfunction

   function automatic logic [15:0] pick_size();
      case ($urandom_range(9))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(3));
         default: return 16'($urandom_range(1, 160));
      endcase
   endfunction

   task automatic random_phase(int count);
      int          roll;
      logic [2:0]  kind;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 36)      kind = RQ_ALLOC;
         else if (roll < 60) kind = RQ_FREE;
         else if (roll < 72) kind = RQ_FIND_ADDR;
         else if (roll < 82) kind = RQ_FIND_SIZE;
         else if (roll < 95) kind = RQ_SPLIT;
         else                kind = 3'($urandom_range(5, 7));
         send(kind, pick_address(), pick_size());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 25;
      recv_gap_pct = 73;

      // No room at all
      set_limit(17'd0);
      send(RQ_ALLOC, 16'd0, 16'd1);
      set_limit(17'd65536);

      // Directed corners: size extremes, merges, trim, bad codes
      send(RQ_ALLOC, 16'd0, 16'd0);
      send(RQ_ALLOC, 16'd0, 16'd65516);
      send(RQ_ALLOC, 16'd0, 16'd1);
      send(RQ_FIND_ADDR, 16'd0, 16'd0);
      send(RQ_FIND_SIZE, 16'hFFFF, 16'd65516);
      send(RQ_SPLIT, 16'd0, 16'd100);
      send(RQ_FREE, 16'd0, 16'd0);
      send(RQ_FREE, 16'd0, 16'd0);
      send(3'd5, 16'hFFFF, 16'hFFFF);
      send(3'd6, 16'd0, 16'd0);
      send(3'd7, 16'd0, 16'd0);
      send(RQ_FREE, 16'd12345, 16'd0);
      send(RQ_SPLIT, 16'd777, 16'd4);
      send(RQ_ALLOC, 16'd0, 16'd1);
      send(RQ_ALLOC, 16'd0, 16'd2);
      send(RQ_ALLOC, 16'd0, 16'd3);
      send(RQ_FREE, 16'd24, 16'd0);
      send(RQ_FREE, 16'd48, 16'd0);
      send(RQ_SPLIT, 16'd0, 16'd65535);
      send(RQ_FIND_SIZE, 16'd0, 16'd9999);
      // Fill the table, then alloc and split against a full table
      for (int n = 0; n < 15; n++) send(RQ_ALLOC, 16'd0, 16'd8);
      send(RQ_ALLOC, 16'd0, 16'd8);
      send(RQ_SPLIT, 16'd0, 16'd1);

      set_limit(17'd2000);
      random_phase(130);

      send_gap_pct = 73;
      recv_gap_pct = 25;
      set_limit(17'd65535);
      random_phase(130);

      send_gap_pct = 0;
      recv_gap_pct = 0;
      set_limit(17'd65536);
      random_phase(140);

      // Drain
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
